// ===== rtl/core/pcs_pkg.sv =====
// Shared types and constants for the parent candidate selector.
package pcs_pkg;

  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned PAN_W     = 64;
  localparam int unsigned UPD_W     = 8;
  localparam int unsigned COST_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COST_W-1:0] COST_ELIG_MAX = 3'd3;
  localparam logic [UPD_W-1:0]  UPD_HALF      = 8'd128;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ARG   = 3'd1,
    ST_BAD_TABLE = 3'd2,
    ST_AMBIG     = 3'd3,
    ST_NONE      = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAN_ID    = 2'd0,
    CFG_MIN_KNOWN = 2'd1,
    CFG_MIN_ID    = 2'd2
  } cfg_idx_t;

  // One classified candidate, front to back.
  typedef struct packed {
    logic              present;
    logic              last;
    logic              pan_bad;
    logic              first_fetch_err;
    logic              cost_err;
    logic              overflow;
    logic              eligible;
    status_t           scan_err;
    logic [IDX_W-1:0]  idx;
    logic [UPD_W-1:0]  upd;
    logic [COST_W-1:0] cost;
  } cand_rec_t;

endpackage

// ===== rtl/core/pcs_front.sv =====
// Front end: config registers, entry counting and per-candidate classification.
module pcs_front #(
  parameter int unsigned MAX_CANDIDATES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcs_pkg::PAN_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_entry_present,
  input  logic [pcs_pkg::PAN_W-1:0]       in_candidate_pan_id,
  input  logic [pcs_pkg::UPD_W-1:0]       in_candidate_update_id,
  input  logic [pcs_pkg::COST_W-1:0]      in_candidate_link_cost,
  input  logic                            in_potential_flag,
  input  logic                            in_fetch_ok,
  input  logic                            in_last_entry,
  input  logic                            q_full,
  output logic                            q_push,
  output pcs_pkg::cand_rec_t              q_wdata
);

  localparam logic [pcs_pkg::CNT_W-1:0] CntMax = pcs_pkg::CNT_W'(MAX_CANDIDATES);

  logic [pcs_pkg::PAN_W-1:0] pan_id_r;
  logic                      min_known_r;
  logic [pcs_pkg::UPD_W-1:0] min_id_r;
  logic [pcs_pkg::CNT_W-1:0] count_r, count_nxt;

  logic                      accept;
  logic                      full;
  logic                      screened;
  logic                      pan_match;
  logic [pcs_pkg::UPD_W-1:0] delta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_id_r    <= '0;
      min_known_r <= 1'b0;
      min_id_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcs_pkg::CFG_PAN_ID:    pan_id_r    <= cfg_wdata;
        pcs_pkg::CFG_MIN_KNOWN: min_known_r <= cfg_wdata[0];
        pcs_pkg::CFG_MIN_ID:    min_id_r    <= cfg_wdata[pcs_pkg::UPD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign full     = (count_r >= CntMax);
  assign q_push   = accept && (in_entry_present || in_last_entry);

  always_comb begin
    delta     = in_candidate_update_id - min_id_r;
    pan_match = (in_candidate_pan_id == pan_id_r);
    q_wdata   = '0;

    q_wdata.present  = in_entry_present && !full;
    q_wdata.overflow = in_entry_present && full;
    q_wdata.last     = in_last_entry;
    q_wdata.pan_bad  = in_last_entry && ((pan_id_r == '0) || (pan_id_r == '1));
    q_wdata.idx      = count_r[pcs_pkg::IDX_W-1:0];
    q_wdata.upd      = in_candidate_update_id;
    q_wdata.cost     = in_candidate_link_cost;

    q_wdata.first_fetch_err = q_wdata.present && (q_wdata.idx == '0) && !in_fetch_ok;
    q_wdata.cost_err        = q_wdata.present && (in_candidate_link_cost == '0);

    screened = q_wdata.present && in_potential_flag &&
               (in_candidate_link_cost <= pcs_pkg::COST_ELIG_MAX);

    if (screened && !in_fetch_ok) begin
      q_wdata.scan_err = pcs_pkg::ST_BAD_TABLE;
    end else if (screened && pan_match && min_known_r && (delta == pcs_pkg::UPD_HALF)) begin
      q_wdata.scan_err = pcs_pkg::ST_AMBIG;
    end else begin
      q_wdata.scan_err = pcs_pkg::ST_OK;
    end

    q_wdata.eligible = screened && in_fetch_ok && pan_match &&
                       (!min_known_r || (delta < pcs_pkg::UPD_HALF));
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (in_last_entry) begin
        count_nxt = '0;
      end else if (in_entry_present && !full) begin
        count_nxt = count_r + pcs_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/pcs_queue.sv =====
// Two-entry queue of classified candidates between front and back.
module pcs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pcs_pkg::cand_rec_t wdata,
  input  logic               pop,
  output pcs_pkg::cand_rec_t rdata,
  output logic               full,
  output logic               empty
);

  pcs_pkg::cand_rec_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

endmodule

// ===== rtl/core/pcs_back.sv =====
// Back end: candidate stores, table flags, dominance scan and result register.
module pcs_back #(
  parameter int unsigned MAX_CANDIDATES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  pcs_pkg::cand_rec_t          q_rdata,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic [pcs_pkg::IDX_W-1:0]   out_best_index,
  output logic [pcs_pkg::UPD_W-1:0]   out_best_update_id,
  output logic [pcs_pkg::COST_W-1:0]  out_best_link_cost
);

  localparam logic [pcs_pkg::IDX_W-1:0] LastIdx = pcs_pkg::IDX_W'(MAX_CANDIDATES - 1);

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [pcs_pkg::UPD_W-1:0]  upd_mem_r  [pcs_pkg::NUM_SLOTS];
  logic [pcs_pkg::COST_W-1:0] cost_mem_r [pcs_pkg::NUM_SLOTS];

  logic [pcs_pkg::NUM_SLOTS-1:0] mask_r;
  logic                          ffe_r;
  logic                          cerr_r;
  logic                          ovf_r;
  logic                          pan_bad_r;
  pcs_pkg::status_t              scan_err_r;

  logic [pcs_pkg::IDX_W-1:0]  scan_idx_r;
  logic                       found_r;
  logic [pcs_pkg::IDX_W-1:0]  best_idx_r;
  logic [pcs_pkg::UPD_W-1:0]  best_upd_r;
  logic [pcs_pkg::COST_W-1:0] best_cost_r;

  logic                       out_valid_r;
  pcs_pkg::status_t           out_status_r;
  logic [pcs_pkg::IDX_W-1:0]  out_idx_r;
  logic [pcs_pkg::UPD_W-1:0]  out_upd_r;
  logic [pcs_pkg::COST_W-1:0] out_cost_r;

  logic                       out_free;
  logic                       emit;
  logic [pcs_pkg::UPD_W-1:0]  cur_upd;
  logic [pcs_pkg::COST_W-1:0] cur_cost;
  logic [pcs_pkg::UPD_W-1:0]  diff;
  logic                       dominant;
  logic                       take;
  pcs_pkg::status_t           status;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_LOAD) && !q_empty;
  assign emit     = (state_r == S_EMIT) && out_free;

  // Candidate under scan against every stored eligible one.
  always_comb begin
    cur_upd  = upd_mem_r[scan_idx_r];
    cur_cost = cost_mem_r[scan_idx_r];
    dominant = 1'b1;
    diff     = '0;
    for (int j = 0; j < pcs_pkg::NUM_SLOTS; j++) begin
      diff = cur_upd - upd_mem_r[j];
      if (mask_r[j] && (diff >= pcs_pkg::UPD_HALF)) begin
        dominant = 1'b0;
      end
    end
    take = mask_r[scan_idx_r] && dominant && (!found_r || (cur_cost < best_cost_r));
  end

  always_comb begin
    if (pan_bad_r) begin
      status = pcs_pkg::ST_BAD_ARG;
    end else if (ffe_r || ovf_r) begin
      status = pcs_pkg::ST_BAD_TABLE;
    end else if (cerr_r) begin
      status = pcs_pkg::ST_BAD_ARG;
    end else if (scan_err_r != pcs_pkg::ST_OK) begin
      status = scan_err_r;
    end else if (mask_r == '0) begin
      status = pcs_pkg::ST_NONE;
    end else if (!found_r) begin
      status = pcs_pkg::ST_AMBIG;
    end else begin
      status = pcs_pkg::ST_OK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: if (q_pop && q_rdata.last) state_nxt = S_SCAN;
      S_SCAN: if (scan_idx_r == LastIdx) state_nxt = S_EMIT;
      S_EMIT: if (out_free) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_rdata.eligible) begin
      upd_mem_r[q_rdata.idx]  <= q_rdata.upd;
      cost_mem_r[q_rdata.idx] <= q_rdata.cost;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && take) begin
      best_idx_r  <= scan_idx_r;
      best_upd_r  <= cur_upd;
      best_cost_r <= cur_cost;
    end
    if (emit) begin
      out_status_r <= status;
      out_idx_r    <= (status == pcs_pkg::ST_OK) ? best_idx_r  : '0;
      out_upd_r    <= (status == pcs_pkg::ST_OK) ? best_upd_r  : '0;
      out_cost_r   <= (status == pcs_pkg::ST_OK) ? best_cost_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      mask_r      <= '0;
      ffe_r       <= 1'b0;
      cerr_r      <= 1'b0;
      ovf_r       <= 1'b0;
      pan_bad_r   <= 1'b0;
      scan_err_r  <= pcs_pkg::ST_OK;
      scan_idx_r  <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (q_pop) begin
        if (q_rdata.eligible) begin
          mask_r[q_rdata.idx] <= 1'b1;
        end
        ffe_r  <= ffe_r  | q_rdata.first_fetch_err;
        cerr_r <= cerr_r | q_rdata.cost_err;
        ovf_r  <= ovf_r  | q_rdata.overflow;
        if (scan_err_r == pcs_pkg::ST_OK) begin
          scan_err_r <= q_rdata.scan_err;
        end
        if (q_rdata.last) begin
          pan_bad_r  <= q_rdata.pan_bad;
          scan_idx_r <= '0;
          found_r    <= 1'b0;
        end
      end

      if (state_r == S_SCAN) begin
        if (take) begin
          found_r <= 1'b1;
        end
        if (scan_idx_r != LastIdx) begin
          scan_idx_r <= scan_idx_r + pcs_pkg::IDX_W'(1);
        end
      end

      if (emit) begin
        out_valid_r <= 1'b1;
        mask_r      <= '0;
        ffe_r       <= 1'b0;
        cerr_r      <= 1'b0;
        ovf_r       <= 1'b0;
        pan_bad_r   <= 1'b0;
        scan_err_r  <= pcs_pkg::ST_OK;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_best_index     = out_idx_r;
  assign out_best_update_id = out_upd_r;
  assign out_best_link_cost = out_cost_r;

endmodule

// ===== rtl/core/parent_candidate_select.sv =====
// Top level of the parent candidate selector: front, queue and back joined.
// Input: one item per cycle while the two-entry queue has room; it stalls when full.
// Result path: the closing item is pushed into the queue and popped by the back,
// the back scans each slot in turn, then the result register is loaded when free.
// The back pops no items while it scans or emits; the queue fills and in_stall rises.
// Sync active-low reset clears config, counters, flags, queue and valids; stores stay.
module parent_candidate_select #(
  parameter int unsigned MAX_CANDIDATES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcs_pkg::PAN_W-1:0]       cfg_wdata,
  // candidate items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_entry_present,
  input  logic [pcs_pkg::PAN_W-1:0]       in_candidate_pan_id,
  input  logic [pcs_pkg::UPD_W-1:0]       in_candidate_update_id,
  input  logic [pcs_pkg::COST_W-1:0]      in_candidate_link_cost,
  input  logic                            in_potential_flag,
  input  logic                            in_fetch_ok,
  input  logic                            in_last_entry,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_status,
  output logic [pcs_pkg::IDX_W-1:0]       out_best_index,
  output logic [pcs_pkg::UPD_W-1:0]       out_best_update_id,
  output logic [pcs_pkg::COST_W-1:0]      out_best_link_cost
);

  // Front classifies each item against the config in force on arrival;
  // the back only stores candidates, accumulates flags, picks the winner and sets the status.
  pcs_pkg::cand_rec_t q_wdata;
  pcs_pkg::cand_rec_t q_rdata;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;

  pcs_front #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_entry_present       (in_entry_present),
    .in_candidate_pan_id    (in_candidate_pan_id),
    .in_candidate_update_id (in_candidate_update_id),
    .in_candidate_link_cost (in_candidate_link_cost),
    .in_potential_flag      (in_potential_flag),
    .in_fetch_ok            (in_fetch_ok),
    .in_last_entry          (in_last_entry),
    .q_full                 (q_full),
    .q_push                 (q_push),
    .q_wdata                (q_wdata)
  );

  // Short queue lets the front keep taking items while the back scans.
  pcs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: stores, dominance scan, registered result with its own stall.
  pcs_back #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_best_index     (out_best_index),
    .out_best_update_id (out_best_update_id),
    .out_best_link_cost (out_best_link_cost)
  );

endmodule
